>>> rtl/cda_pkg.sv
// cda_pkg: shared types and constants of the counter delta accumulator
// no dependencies; used by cda_lane, cda_ctrl, counter_delta_accumulator and the testbench
package cda_pkg;

    // counter lanes, one per raw counter of an item
    localparam int NUM_LANES = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_ASSUME_WIDE = 2'd0;
    localparam logic [1:0] CFG_MAX_NARROW  = 2'd1;
    localparam logic [1:0] CFG_MAX_WIDE    = 2'd2;

    // configuration reset values
    localparam logic [31:0] MAX_NARROW_RST = 32'd2147483647;
    localparam logic [63:0] MAX_WIDE_RST   = 64'd1099511627776;

    // lanes whose delta is checked against a limit: rx/tx bytes and packets
    localparam logic [NUM_LANES-1:0] CHECK_MASK = 8'b0011_0011;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_MERGE
    } t_state;

    // control from the merge stage to every lane
    typedef struct packed {
        logic acc;       // item accepted, read port state
        logic calc;      // register delta and limit check
        logic fire;      // commit state and load the result
        logic add;       // deltas go into the totals
        logic seen;      // port had a snapshot before
        logic wide;      // byte deltas are 64-bit for this item
        logic in_range;  // port index below the port count
    } t_lane_ctl;

endpackage

>>> rtl/cda_lane.sv
// cda_lane: one counter lane with its last-raw and total memories
// depends on cda_pkg; byte lanes also keep the low 32 bits for narrow mode
module cda_lane
    import cda_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int AW       = 4,
    parameter bit IS_BYTES = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_lane_ctl       i_ctl,
    input  logic [AW-1:0]   i_addr,
    input  logic [63:0]     i_raw,
    input  logic [63:0]     i_limit,
    output logic            o_exceed,
    output logic [63:0]     o_total
);

    logic [63:0] mem_raw [DEPTH];
    logic [63:0] mem_tot [DEPTH];

    logic [AW-1:0] r_addr;
    logic [63:0]   r_raw;
    logic [63:0]   r_last;
    logic [63:0]   r_tot;
    logic [63:0]   r_base;
    logic [63:0]   r_delta;
    logic          r_exceed;
    logic [63:0]   r_out_total;
    logic [31:0]   w_nar;
    logic [63:0]   n_delta;
    logic [63:0]   n_total;

    // port state read on accept, written back on commit
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_addr <= i_addr;
            r_raw  <= i_raw;
            r_last <= mem_raw[i_addr];
            r_tot  <= mem_tot[i_addr];
        end
        if (i_ctl.fire && i_ctl.in_range) begin
            mem_raw[r_addr] <= r_raw;
            mem_tot[r_addr] <= n_total;
        end
    end

    // narrow byte base, with valid bits so unwritten entries read as zero
    generate
        if (IS_BYTES) begin : g_narrow
            logic [31:0] mem_nar [DEPTH];
            logic        r_nv [DEPTH];
            logic [31:0] r_nar;

            always_ff @(posedge i_clk) begin
                if (i_ctl.acc) begin
                    r_nar <= r_nv[i_addr] ? mem_nar[i_addr] : 32'd0;
                end
                if (i_ctl.fire && i_ctl.in_range && !i_ctl.wide) begin
                    mem_nar[r_addr] <= r_raw[31:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < DEPTH; k++) begin
                        r_nv[k] <= 1'b0;
                    end
                end else if (i_ctl.fire && i_ctl.in_range && !i_ctl.wide) begin
                    r_nv[r_addr] <= 1'b1;
                end
            end

            assign w_nar = r_nar;
        end else begin : g_no_narrow
            assign w_nar = 32'd0;
        end
    endgenerate

    // delta since the last snapshot
    always_comb begin
        if (IS_BYTES && !i_ctl.wide) begin
            n_delta = {32'd0, r_raw[31:0] - w_nar};
        end else begin
            n_delta = r_raw - r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_delta  <= n_delta;
            r_exceed <= (n_delta > i_limit);
            r_base   <= i_ctl.seen ? r_tot : 64'd0;
        end
    end

    // total after this item
    assign n_total = r_base + (i_ctl.add ? r_delta : 64'd0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_out_total <= i_ctl.in_range ? n_total : 64'd0;
        end
    end

    assign o_exceed = r_exceed;
    assign o_total  = r_out_total;

endmodule

>>> rtl/cda_ctrl.sv
// cda_ctrl: sequencer, configuration, seen bits, wide mode and merge decision
// depends on cda_pkg; drives the lane control struct for all cda_lane copies
module cda_ctrl
    import cda_pkg::*;
#(
    parameter int NUM_PORTS = 16,
    parameter int DEPTH     = 16,
    parameter int AW        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_port,
    input  logic [AW-1:0]        i_addr,
    input  logic [31:0]          i_rx_hi,
    input  logic [31:0]          i_tx_hi,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [NUM_LANES-1:0] i_exceed,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_lane_ctl            o_ctl,
    output logic [63:0]          o_lim_bytes,
    output logic [63:0]          o_lim_pkt,
    output logic [3:0]           o_port_out,
    output logic                 o_first,
    output logic                 o_disc,
    output logic                 o_wide_now
);

    t_state        r_state, n_state;
    logic          r_cfg_wide;
    logic [31:0]   r_max_narrow;
    logic [63:0]   r_max_wide;
    logic          r_wide_mode;
    logic          r_seen_bits [DEPTH];
    logic [AW-1:0] r_addr;
    logic [3:0]    r_port;
    logic          r_seen;
    logic          r_wide;
    logic          r_go;
    logic          r_in_range;
    logic          r_out_valid;
    logic          r_first_q;
    logic          r_disc_q;
    logic          r_wide_q;
    logic          w_acc;
    logic          w_fire;
    logic          w_disc;
    logic          w_in_range;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wide   <= 1'b0;
            r_max_narrow <= MAX_NARROW_RST;
            r_max_wide   <= MAX_WIDE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ASSUME_WIDE: r_cfg_wide   <= i_cfg_data[0];
                CFG_MAX_NARROW:  r_max_narrow <= i_cfg_data[31:0];
                CFG_MAX_WIDE:    r_max_wide   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state = r_state;
        w_acc   = 1'b0;
        w_fire  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_acc   = 1'b1;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_fire  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_range = (32'(i_port) < 32'(NUM_PORTS));

    // item context captured on accept
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_addr     <= i_addr;
            r_port     <= i_port;
            r_in_range <= w_in_range;
            r_seen     <= w_in_range && r_seen_bits[i_addr];
            r_wide     <= r_cfg_wide || r_wide_mode;
            r_go       <= !(r_cfg_wide || r_wide_mode) &&
                          ((i_rx_hi != 32'd0) || (i_tx_hi != 32'd0));
        end
    end

    // merge: any checked lane over its limit discards the deltas
    assign w_disc = r_seen && ((i_exceed & CHECK_MASK) != '0);

    // seen bits and sticky wide mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_seen_bits[k] <= 1'b0;
            end
        end else if (w_fire && r_in_range) begin
            r_seen_bits[r_addr] <= 1'b1;
            if (r_go) begin
                r_wide_mode <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_port_out <= r_port;
            r_first_q  <= r_in_range && !r_seen;
            r_disc_q   <= r_in_range && w_disc;
            r_wide_q   <= r_cfg_wide || r_wide_mode || (r_in_range && r_go);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_first     = r_first_q;
    assign o_disc      = r_disc_q;
    assign o_wide_now  = r_wide_q;

    // limits for the lanes
    assign o_lim_bytes = r_wide ? r_max_wide : {32'd0, r_max_narrow};
    assign o_lim_pkt   = {32'd0, r_max_narrow};

    // lane control
    always_comb begin
        o_ctl.acc      = w_acc;
        o_ctl.calc     = (r_state == S_CALC);
        o_ctl.fire     = w_fire;
        o_ctl.add      = r_seen && !w_disc;
        o_ctl.seen     = r_seen;
        o_ctl.wide     = r_wide;
        o_ctl.in_range = r_in_range;
    end

endmodule

>>> rtl/counter_delta_accumulator.sv
// counter_delta_accumulator: top level, eight counter lanes and the merge stage
// depends on cda_pkg, cda_lane and cda_ctrl
//
// Takes snapshots of eight raw counters for one port and returns the port's
// running totals after adding the deltas since its previous snapshot. Each
// item passes three steps: accept reads the port's state from the per-lane
// memories, calc forms and checks the deltas, and merge combines the limit
// checks, writes the state back and loads the output register. A new item is
// accepted only after the last one has left merge; the output register lets
// the next item be accepted while a result still waits. State is cleared at
// reset through valid bits, so no clearing pass is needed. Port indexes at or
// above NUM_PORTS leave state unchanged and return zero totals.
module counter_delta_accumulator
    import cda_pkg::*;
#(
    parameter int NUM_PORTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_port,
    input  logic [63:0] i_rx_bytes,
    input  logic [63:0] i_rx_packets,
    input  logic [63:0] i_rx_errors,
    input  logic [63:0] i_rx_drops,
    input  logic [63:0] i_tx_bytes,
    input  logic [63:0] i_tx_packets,
    input  logic [63:0] i_tx_errors,
    input  logic [63:0] i_tx_drops,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_port_out,
    output logic [63:0] o_total_rx_bytes,
    output logic [63:0] o_total_rx_packets,
    output logic [63:0] o_total_rx_errors,
    output logic [63:0] o_total_rx_drops,
    output logic [63:0] o_total_tx_bytes,
    output logic [63:0] o_total_tx_packets,
    output logic [63:0] o_total_tx_errors,
    output logic [63:0] o_total_tx_drops,
    output logic        o_first_sample,
    output logic        o_discontinuity,
    output logic        o_wide_now
);

    // only sixteen ports are addressable through the 4-bit index
    localparam int DEPTH = (NUM_PORTS < 16) ? NUM_PORTS : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_lane_ctl             w_ctl;
    logic [AW-1:0]         w_addr;
    logic [63:0]           w_raw   [NUM_LANES];
    logic [63:0]           w_total [NUM_LANES];
    logic [NUM_LANES-1:0]  w_exceed;
    logic [63:0]           w_lim_bytes;
    logic [63:0]           w_lim_pkt;

    assign w_addr = i_port[AW-1:0];

    // lane order follows the item's counter order
    assign w_raw[0] = i_rx_bytes;
    assign w_raw[1] = i_rx_packets;
    assign w_raw[2] = i_rx_errors;
    assign w_raw[3] = i_rx_drops;
    assign w_raw[4] = i_tx_bytes;
    assign w_raw[5] = i_tx_packets;
    assign w_raw[6] = i_tx_errors;
    assign w_raw[7] = i_tx_drops;

    cda_ctrl #(
        .NUM_PORTS (NUM_PORTS),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_port      (i_port),
        .i_addr      (w_addr),
        .i_rx_hi     (i_rx_bytes[63:32]),
        .i_tx_hi     (i_tx_bytes[63:32]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_exceed    (w_exceed),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_ctl       (w_ctl),
        .o_lim_bytes (w_lim_bytes),
        .o_lim_pkt   (w_lim_pkt),
        .o_port_out  (o_port_out),
        .o_first     (o_first_sample),
        .o_disc      (o_discontinuity),
        .o_wide_now  (o_wide_now)
    );

    // counter lanes; byte lanes carry the narrow-mode base
    generate
        for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
            localparam bit BYTES = (g == 0) || (g == 4);
            cda_lane #(
                .DEPTH    (DEPTH),
                .AW       (AW),
                .IS_BYTES (BYTES)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_addr   (w_addr),
                .i_raw    (w_raw[g]),
                .i_limit  (BYTES ? w_lim_bytes : w_lim_pkt),
                .o_exceed (w_exceed[g]),
                .o_total  (w_total[g])
            );
        end
    endgenerate

    assign o_total_rx_bytes   = w_total[0];
    assign o_total_rx_packets = w_total[1];
    assign o_total_rx_errors  = w_total[2];
    assign o_total_rx_drops   = w_total[3];
    assign o_total_tx_bytes   = w_total[4];
    assign o_total_tx_packets = w_total[5];
    assign o_total_tx_errors  = w_total[6];
    assign o_total_tx_drops   = w_total[7];

endmodule

>>> tb/sv/cda_total_checker.sv
// cda_total_checker: watches the item and result channels of counter_delta_accumulator,
// keeps its own per-port counter state and compares every result field by field
// depends on cda_pkg
`timescale 1ns / 1ps

module cda_total_checker
    import cda_pkg::*;
#(
    parameter int NUM_PORTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [3:0]  i_port,
    input  logic [63:0] i_rx_bytes,
    input  logic [63:0] i_rx_packets,
    input  logic [63:0] i_rx_errors,
    input  logic [63:0] i_rx_drops,
    input  logic [63:0] i_tx_bytes,
    input  logic [63:0] i_tx_packets,
    input  logic [63:0] i_tx_errors,
    input  logic [63:0] i_tx_drops,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  o_port_out,
    input  logic [63:0] o_total_rx_bytes,
    input  logic [63:0] o_total_rx_packets,
    input  logic [63:0] o_total_rx_errors,
    input  logic [63:0] o_total_rx_drops,
    input  logic [63:0] o_total_tx_bytes,
    input  logic [63:0] o_total_tx_packets,
    input  logic [63:0] o_total_tx_errors,
    input  logic [63:0] o_total_tx_drops,
    input  logic        o_first_sample,
    input  logic        o_discontinuity,
    input  logic        o_wide_now,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);

    // counter lanes inside a snapshot
    localparam int LANE_RXB = 0;
    localparam int LANE_RXP = 1;
    localparam int LANE_TXB = 4;
    localparam int LANE_TXP = 5;

    typedef struct packed {
        logic [3:0]        port;
        logic [7:0][63:0]  totals;
        logic              first;
        logic              disc;
        logic              wide;
    } t_port_totals;

    string total_names [8] = '{"total_rx_bytes", "total_rx_packets", "total_rx_errors",
                               "total_rx_drops", "total_tx_bytes", "total_tx_packets",
                               "total_tx_errors", "total_tx_drops"};

    // register copies
    logic        assume_wide;
    logic [31:0] narrow_limit;
    logic [63:0] wide_limit;

    // per-port counter state
    logic             port_seen    [NUM_PORTS];
    logic [7:0][63:0] prev_raw     [NUM_PORTS];
    logic [1:0][31:0] prev_bytes32 [NUM_PORTS];
    logic [7:0][63:0] port_totals  [NUM_PORTS];
    logic             wide_latched;

    t_port_totals expected_totals [$];

    // applies one snapshot to the port state and returns the totals it should produce
    function automatic t_port_totals fold_snapshot(logic [3:0] port, logic [7:0][63:0] raw);
        t_port_totals     r;
        logic [7:0][63:0] delta;
        logic [63:0]      byte_limit;
        logic [63:0]      pkt_limit;
        logic [31:0]      lo;
        logic             go_wide;
        logic             first;
        logic             disc;
        int               p;
        r = '0;
        r.port = port;
        p = port;
        if (p >= NUM_PORTS) begin
            r.wide = assume_wide | wide_latched;
            return r;
        end
        for (int i = 0; i < 8; i++) begin
            delta[i] = raw[i] - prev_raw[p][i];
        end
        pkt_limit = {32'b0, narrow_limit};
        if (assume_wide || wide_latched) begin
            byte_limit = wide_limit;
        end else begin
            // narrow mode: byte deltas on the low 32 bits only
            go_wide = 1'b0;
            lo = raw[LANE_RXB][31:0];
            delta[LANE_RXB] = {32'b0, lo - prev_bytes32[p][0]};
            prev_bytes32[p][0] = lo;
            if (raw[LANE_RXB][63:32] != '0) go_wide = 1'b1;
            lo = raw[LANE_TXB][31:0];
            delta[LANE_TXB] = {32'b0, lo - prev_bytes32[p][1]};
            prev_bytes32[p][1] = lo;
            if (raw[LANE_TXB][63:32] != '0) go_wide = 1'b1;
            byte_limit = pkt_limit;
            if (go_wide) wide_latched = 1'b1;
        end
        first = !port_seen[p];
        port_seen[p] = 1'b1;
        disc = !first && (delta[LANE_RXB] > byte_limit || delta[LANE_TXB] > byte_limit ||
                          delta[LANE_RXP] > pkt_limit || delta[LANE_TXP] > pkt_limit);
        if (!first && !disc) begin
            for (int i = 0; i < 8; i++) begin
                port_totals[p][i] = port_totals[p][i] + delta[i];
            end
        end
        prev_raw[p] = raw;
        r.totals = port_totals[p];
        r.first = first;
        r.disc = disc;
        r.wide = assume_wide | wide_latched;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            o_mismatches++;
        end
    endtask

    // monitor both channels and the register port
    always @(posedge i_clk) begin : monitor
        t_port_totals     want;
        logic [7:0][63:0] got;
        logic [7:0][63:0] raw;
        if (!i_rst_n) begin
            assume_wide = 1'b0;
            narrow_limit = MAX_NARROW_RST;
            wide_limit = MAX_WIDE_RST;
            wide_latched = 1'b0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                port_seen[p] = 1'b0;
                prev_raw[p] = '0;
                prev_bytes32[p] = '0;
                port_totals[p] = '0;
            end
            expected_totals.delete();
            o_mismatches = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ASSUME_WIDE: assume_wide = i_cfg_data[0];
                    CFG_MAX_NARROW:  narrow_limit = i_cfg_data[31:0];
                    CFG_MAX_WIDE:    wide_limit = i_cfg_data;
                    default: ;
                endcase
            end
            // compare an accepted result with the oldest prediction
            if (o_out_valid && i_out_ready) begin
                if (expected_totals.size() == 0) begin
                    $error("result for port %0d arrived with no snapshot outstanding",
                           o_port_out);
                    o_mismatches++;
                end else begin
                    want = expected_totals.pop_front();
                    got = {o_total_tx_drops, o_total_tx_errors, o_total_tx_packets,
                           o_total_tx_bytes, o_total_rx_drops, o_total_rx_errors,
                           o_total_rx_packets, o_total_rx_bytes};
                    check_field("port_out", 64'(want.port), 64'(o_port_out));
                    for (int i = 0; i < 8; i++) begin
                        check_field(total_names[i], want.totals[i], got[i]);
                    end
                    check_field("first_sample", 64'(want.first), 64'(o_first_sample));
                    check_field("discontinuity", 64'(want.disc), 64'(o_discontinuity));
                    check_field("wide_now", 64'(want.wide), 64'(o_wide_now));
                    o_checked++;
                end
            end
            // predict for an accepted item
            if (i_in_valid && o_in_ready) begin
                raw = {i_tx_drops, i_tx_errors, i_tx_packets, i_tx_bytes,
                       i_rx_drops, i_rx_errors, i_rx_packets, i_rx_bytes};
                expected_totals.push_back(fold_snapshot(i_port, raw));
            end
        end
        o_pending = expected_totals.size();
    end

endmodule

>>> tb/sv/tb_counter_delta_accumulator.sv
// tb_counter_delta_accumulator: drives counter snapshots and register settings into
// counter_delta_accumulator and gives the verdict; depends on cda_pkg and cda_total_checker
`timescale 1ns / 1ps

module tb_counter_delta_accumulator;
    import cda_pkg::*;

    localparam int LANE_RXB = 0;
    localparam int LANE_RXP = 1;
    localparam int LANE_RXE = 2;
    localparam int LANE_RXD = 3;
    localparam int LANE_TXB = 4;
    localparam int LANE_TXP = 5;
    localparam int LANE_TXE = 6;
    localparam int LANE_TXD = 7;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [3:0]  i_port = '0;
    logic [63:0] i_rx_bytes = '0;
    logic [63:0] i_rx_packets = '0;
    logic [63:0] i_rx_errors = '0;
    logic [63:0] i_rx_drops = '0;
    logic [63:0] i_tx_bytes = '0;
    logic [63:0] i_tx_packets = '0;
    logic [63:0] i_tx_errors = '0;
    logic [63:0] i_tx_drops = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_port_out;
    logic [63:0] o_total_rx_bytes;
    logic [63:0] o_total_rx_packets;
    logic [63:0] o_total_rx_errors;
    logic [63:0] o_total_rx_drops;
    logic [63:0] o_total_tx_bytes;
    logic [63:0] o_total_tx_packets;
    logic [63:0] o_total_tx_errors;
    logic [63:0] o_total_tx_drops;
    logic        o_first_sample;
    logic        o_discontinuity;
    logic        o_wide_now;
    int          o_mismatches;
    int          o_pending;
    int          o_checked;

    // stimulus state
    logic             calm = 1'b0;
    logic             narrow_only;
    logic [31:0]      narrow_cfg;
    logic [63:0]      wide_cfg;
    logic [7:0][63:0] last_sent [16];
    int               n_sent = 0;
    int               n_settings = 0;
    int               stall_cycles = 0;

    counter_delta_accumulator dut (.*);
    cda_total_checker totals_check (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side stalls at random except in calm stretches
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 13);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, o_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // next raw value of one counter lane
    function automatic logic [63:0] next_count(logic [63:0] prev, int lane, bit clean);
        int          pick;
        logic [63:0] lim;
        logic [63:0] v;
        bit          is_bytes;
        is_bytes = (lane == LANE_RXB) || (lane == LANE_TXB);
        lim = (is_bytes && !narrow_only) ? wide_cfg : {32'b0, narrow_cfg};
        pick = clean ? $urandom_range(71) : $urandom_range(99);
        if (pick < 60)      v = prev + 64'($urandom_range(4095));
        else if (pick < 72) v = prev + {32'b0, $urandom};
        else if (pick < 78) v = prev + lim - 64'd1 + 64'($urandom_range(2));
        else if (pick < 84) v = prev;
        else if (pick < 88) v = prev - 64'($urandom_range(1, 1000));
        else if (pick < 92) v = ALL_ONES - 64'($urandom_range(255));
        else                v = {$urandom, $urandom};
        if (is_bytes && narrow_only) v[63:32] = '0;
        return v;
    endfunction

    // present one item and hold it until accepted
    task automatic send_snapshot(logic [3:0] port, logic [7:0][63:0] raw);
        logic took;
        i_in_valid <= 1'b1;
        i_port <= port;
        i_rx_bytes <= raw[LANE_RXB];
        i_rx_packets <= raw[LANE_RXP];
        i_rx_errors <= raw[LANE_RXE];
        i_rx_drops <= raw[LANE_RXD];
        i_tx_bytes <= raw[LANE_TXB];
        i_tx_packets <= raw[LANE_TXP];
        i_tx_errors <= raw[LANE_TXE];
        i_tx_drops <= raw[LANE_TXD];
        last_sent[port] = raw;
        n_sent++;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic random_snapshot();
        logic [3:0]       port;
        logic [7:0][63:0] raw;
        bit               clean;
        port = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        clean = $urandom_range(99) < 70;
        for (int lane = 0; lane < 8; lane++) begin
            raw[lane] = next_count(last_sent[port][lane], lane, clean);
        end
        if (!calm) begin
            while ($urandom_range(99) < 13) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        send_snapshot(port, raw);
    endtask

    // stop sending until every result is back, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (o_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all registers while idle; upper data bits are noise the block must drop
    task automatic set_regs(bit wide_bytes, logic [31:0] nlim, logic [63:0] wlim);
        logic [63:0] d;
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        d = {$urandom, $urandom};
        d[0] = wide_bytes;
        i_cfg_index <= CFG_ASSUME_WIDE;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_NARROW;
        i_cfg_data <= {$urandom, nlim};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_WIDE;
        i_cfg_data <= wlim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        narrow_cfg = nlim;
        wide_cfg = wlim;
        n_settings++;
    endtask

    task automatic run_phase(int n, bit wide_bytes, logic [31:0] nlim, logic [63:0] wlim,
                             bit narrow);
        set_regs(wide_bytes, nlim, wlim);
        narrow_only = narrow;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) drain();
            random_snapshot();
        end
    endtask

    // stimulus
    initial begin
        logic [7:0][63:0] v;
        for (int p = 0; p < 16; p++) last_sent[p] = '0;
        narrow_only = 1'b1;
        narrow_cfg = MAX_NARROW_RST;
        wide_cfg = MAX_WIDE_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first snapshot, then plain increments
        v = '0;
        send_snapshot(4'd0, v);
        v = {64'd4, 64'd3, 64'd20, 64'd2000, 64'd2, 64'd1, 64'd10, 64'd1000};
        send_snapshot(4'd0, v);
        // highest port at the top of every range, then wrapping around
        v = {ALL_ONES, ALL_ONES, ALL_ONES, 64'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES,
             64'hFFFF_FFFF};
        send_snapshot(4'd15, v);
        v = {64'd0, 64'd0, 64'd7, 64'h20, 64'd0, 64'd0, 64'd5, 64'h10};
        send_snapshot(4'd15, v);
        // byte delta exactly at the limit, then one above on each checked lane
        v = last_sent[0];
        v[LANE_RXB] = 64'h8000_03E7;
        send_snapshot(4'd0, v);
        v[LANE_RXB] = 64'h0000_03E7;
        send_snapshot(4'd0, v);
        v[LANE_TXB] = v[LANE_TXB] + 64'h8000_0000;
        send_snapshot(4'd0, v);
        v[LANE_RXP] = v[LANE_RXP] + 64'h8000_0000;
        send_snapshot(4'd0, v);
        v[LANE_TXP] = v[LANE_TXP] + 64'h8000_0000;
        send_snapshot(4'd0, v);
        // huge error and drop deltas are never judged
        v[LANE_RXE] = 64'h8000_0000_0000_0001;
        v[LANE_RXD] = ALL_ONES;
        v[LANE_TXE] = 64'h8000_0000_0000_0003;
        v[LANE_TXD] = 64'd0;
        send_snapshot(4'd0, v);
        // packet counter going backwards
        v[LANE_RXP] = 64'd5;
        send_snapshot(4'd0, v);
        // unchanged counters add zero
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        v[LANE_RXB][63:32] = '0;
        v[LANE_TXB][63:32] = '0;
        send_snapshot(4'd7, v);
        send_snapshot(4'd7, v);
        // zero limit: only unchanged counters pass
        set_regs(1'b0, 32'd0, MAX_WIDE_RST);
        send_snapshot(4'd7, v);
        v[LANE_RXB][31:0] = v[LANE_RXB][31:0] + 32'd1;
        send_snapshot(4'd7, v);
        // full narrow limit: any 32-bit byte delta passes, a 2^32 packet delta does not
        set_regs(1'b0, 32'hFFFF_FFFF, MAX_WIDE_RST);
        v[LANE_RXB][31:0] = v[LANE_RXB][31:0] + 32'hFFFF_FFFF;
        send_snapshot(4'd7, v);
        v[LANE_TXP] = v[LANE_TXP] + 64'h1_0000_0000;
        send_snapshot(4'd7, v);
        // wide by register, zero then full wide limit
        set_regs(1'b1, MAX_NARROW_RST, 64'd0);
        v[LANE_RXB] = 64'h1234_5678_9ABC_DEF0;
        send_snapshot(4'd7, v);
        set_regs(1'b1, MAX_NARROW_RST, ALL_ONES);
        v[LANE_RXB] = ALL_ONES;
        v[LANE_TXB] = 64'hFFFF_0000_0000_0000;
        send_snapshot(4'd7, v);
        // back to narrow: byte deltas against the last narrow values
        set_regs(1'b0, MAX_NARROW_RST, MAX_WIDE_RST);
        v[LANE_RXB] = 64'h100;
        v[LANE_TXB] = 64'h200;
        send_snapshot(4'd7, v);
        v[LANE_RXB] = 64'h180;
        send_snapshot(4'd7, v);

        // random traffic in narrow mode
        run_phase(300, 1'b0, MAX_NARROW_RST, MAX_WIDE_RST, 1'b1);
        run_phase(200, 1'b0, 32'hFFFF_FFFF, MAX_WIDE_RST, 1'b1);
        run_phase(100, 1'b0, 32'd0, MAX_WIDE_RST, 1'b1);
        run_phase(150, 1'b0, $urandom, {$urandom, $urandom}, 1'b1);
        // wide by register only
        run_phase(150, 1'b1, MAX_NARROW_RST, MAX_WIDE_RST, 1'b0);
        run_phase(80, 1'b1, MAX_NARROW_RST, 64'd0, 1'b0);
        run_phase(120, 1'b1, $urandom, ALL_ONES, 1'b0);
        run_phase(150, 1'b0, MAX_NARROW_RST, MAX_WIDE_RST, 1'b1);

        // a byte value above 32 bits switches to wide for good
        drain();
        v = last_sent[3];
        v[LANE_RXB] = {32'h1, v[LANE_RXB][31:0] + 32'd64};
        send_snapshot(4'd3, v);
        v[LANE_RXB] = v[LANE_RXB] + 64'd128;
        v[LANE_TXB] = 64'h2_0000_0000;
        send_snapshot(4'd3, v);

        // random traffic after the switch, with a calm stretch first
        calm <= 1'b1;
        run_phase(250, 1'b0, MAX_NARROW_RST, MAX_WIDE_RST, 1'b0);
        calm <= 1'b0;
        run_phase(150, 1'b1, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0);
        run_phase(100, 1'b0, 32'd0, ALL_ONES, 1'b0);
        run_phase(100, 1'b0, $urandom, {32'b0, $urandom}, 1'b0);

        drain();
        @(negedge i_clk);
        $display("%0d snapshots over %0d register settings, narrow and wide byte modes;",
                 n_sent, n_settings);
        $display("%0d results compared, %0d field mismatches", o_checked, o_mismatches);
        if (o_mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cda_pkg.sv
rtl/cda_lane.sv
rtl/cda_ctrl.sv
rtl/counter_delta_accumulator.sv
tb/sv/cda_total_checker.sv
tb/sv/tb_counter_delta_accumulator.sv
